// ===== hdl/u8d_pkg.sv =====
// Package of shared types and constants for the UTF-8 byte stream decoder.
`default_nettype none

package u8d_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD  = 2'd1;
    localparam logic [1:0] ST_BAD_CONT  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // Widths of the decoder fields.
    localparam int unsigned CP_W    = 31;
    localparam int unsigned REM_W   = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CONT_W  = 6;

    // Payload mask of a lead byte, indexed by its count of continuation bytes.
    localparam logic [BYTE_W-1:0] LEAD_MASK [0:5] = '{
        8'b0111_1111, 8'b0001_1111, 8'b0000_1111,
        8'b0000_0111, 8'b0000_0011, 8'b0000_0001
    };

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [CP_W-1:0]  acc;
        logic [REM_W-1:0] remaining;
        logic             halted;
    } t_state;

    // One result transaction.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [1:0]      status;
        logic            text_done;
    } t_result;

    // Everything the decoder works out for one byte.
    typedef struct packed {
        t_state  next_state;
        logic    emit;
        t_result result;
    } t_step;

endpackage

`default_nettype wire

// ===== hdl/u8d_if.sv =====
// Handshake interfaces for the byte input and the code point output channels.
`default_nettype none

interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface u8d_cp_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_point;
    logic [1:0]  status;
    logic        text_done;

    modport source (output valid, output code_point, output status, output text_done,
                    input ready);
    modport sink   (input valid, input code_point, input status, input text_done,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/u8d_decode.sv =====
// Combinational decode of one byte against the current decoder state.
`default_nettype none

module u8d_decode import u8d_pkg::*; (
    input  t_state            i_state,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output t_step             o_step
);

    logic [REM_W-1:0]  w_extra;
    logic              w_bad_lead;
    logic              w_cont_ok;
    logic [BYTE_W-1:0] w_lead_bits;
    logic [CP_W-1:0]   w_acc;
    logic [REM_W-1:0]  w_rem;
    logic              w_fail;
    logic [1:0]        w_fail_status;

    // Count of continuation bytes announced by a lead byte.
    always_comb begin
        w_bad_lead = 1'b0;
        unique case (i_byte) inside
            8'b0???_????: w_extra = 3'd0;
            8'b10??_????: w_extra = 3'd0;
            8'b110?_????: w_extra = 3'd1;
            8'b1110_????: w_extra = 3'd2;
            8'b1111_0???: w_extra = 3'd3;
            8'b1111_10??: w_extra = 3'd4;
            8'b1111_110?: w_extra = 3'd5;
            default: begin
                w_extra    = 3'd0;
                w_bad_lead = 1'b1;
            end
        endcase
    end

    assign w_lead_bits = i_byte & LEAD_MASK[w_extra];
    assign w_cont_ok   = (i_byte[7:6] == 2'b10);

    // State update and result selection.
    always_comb begin
        o_step        = '0;
        o_step.next_state = i_state;
        w_acc         = i_state.acc;
        w_rem         = i_state.remaining;
        w_fail        = 1'b0;
        w_fail_status = ST_OK;

        if (i_state.halted) begin
            // Bytes are dropped until the end of the text rearms the decoder.
            if (i_last) begin
                o_step.next_state = '0;
            end
        end else begin
            if (i_state.remaining == '0) begin
                if (w_bad_lead) begin
                    w_fail        = 1'b1;
                    w_fail_status = ST_BAD_LEAD;
                end else begin
                    w_acc = {{(CP_W-BYTE_W){1'b0}}, w_lead_bits};
                    w_rem = w_extra;
                end
            end else begin
                if (!w_cont_ok) begin
                    w_fail        = 1'b1;
                    w_fail_status = ST_BAD_CONT;
                end else begin
                    w_acc = {i_state.acc[CP_W-CONT_W-1:0], i_byte[CONT_W-1:0]};
                    w_rem = i_state.remaining - 3'd1;
                end
            end

            // A text that ends with bytes still owed is truncated.
            if (!w_fail && (w_rem != '0) && i_last) begin
                w_fail        = 1'b1;
                w_fail_status = ST_TRUNCATED;
            end

            if (w_fail) begin
                o_step.emit              = 1'b1;
                o_step.result.code_point = '0;
                o_step.result.status     = w_fail_status;
                o_step.result.text_done  = i_last;
                o_step.next_state.acc       = '0;
                o_step.next_state.remaining = '0;
                o_step.next_state.halted    = !i_last;
            end else if (w_rem != '0) begin
                o_step.next_state.acc       = w_acc;
                o_step.next_state.remaining = w_rem;
                o_step.next_state.halted    = 1'b0;
            end else begin
                o_step.emit              = 1'b1;
                o_step.result.code_point = w_acc;
                o_step.result.status     = ST_OK;
                o_step.result.text_done  = i_last;
                o_step.next_state        = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/u8d_out_stage.sv =====
// Result register that drives the output channel.
`default_nettype none

module u8d_out_stage import u8d_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_result       i_result,
    output logic          o_free,
    u8d_cp_if.source      o_out
);

    logic    r_valid;
    t_result r_result;

    // The register can take a new result when empty or when drained this cycle.
    assign o_free = !r_valid || o_out.ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.code_point = r_result.code_point;
    assign o_out.status     = r_result.status;
    assign o_out.text_done  = r_result.text_done;

endmodule

`default_nettype wire

// ===== hdl/utf8_byte_stream_decoder.sv =====
// Top level of the UTF-8 byte stream decoder.
//
//   channel  direction  payload                                 handshake
//   i_in     in         byte_value[7:0], last_byte              valid / ready
//   o_out    out        code_point[30:0], status[1:0], text_done valid / ready
//
// Each byte passes an input register, combinational decode logic and then a
// result register, which presents its result on the output channel.
// One byte is taken per cycle while the result register drains every cycle.
// A byte that completes no code point and shows no error gives no result.
// A stalled output holds its result; the input register then holds one byte.
// Synchronous reset empties both registers and clears the decoder state.
`default_nettype none

module utf8_byte_stream_decoder import u8d_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8d_byte_if.sink  i_in,
    u8d_cp_if.source  o_out
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    t_state            r_state;
    t_step             w_step;
    logic              w_out_free;
    logic              w_advance;

    // A byte moves on when the result register has room for its result.
    assign w_advance  = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.byte_value;
            r_in_last <= i_in.last_byte;
        end
    end

    // Decoder state, updated once per byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= w_step.next_state;
        end
    end

    u8d_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_step  (w_step)
    );

    u8d_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_step.emit),
        .i_result (w_step.result),
        .o_free   (w_out_free),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== hdl/u8d_checker.sv =====
// Port-level checks on the decoder output channel, bound to the top level.
`default_nettype none

module u8d_checker import u8d_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [30:0] i_code_point,
    input logic [1:0]  i_status,
    input logic        i_text_done
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_code_point) && $stable(i_status)
            && $stable(i_text_done))
        else $error("output transaction changed while stalled");

    // Error results carry no code point.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_code_point == '0))
        else $error("error result with non-zero code point");

    // Truncation is only reported on the last byte of a text.
    a_trunc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_TRUNCATED) |-> i_text_done)
        else $error("truncation reported before the end of the text");

endmodule

bind utf8_byte_stream_decoder u8d_checker u_u8d_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_code_point (o_out.code_point),
    .i_status     (o_out.status),
    .i_text_done  (o_out.text_done)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the UTF-8 byte stream decoder: directed table, random texts.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int BYTES_PER_PHASE = 132;
    localparam int N_PHASES        = 4;
    // Percentages of idle sender cycles and stalled receiver cycles, one pair per phase.
    localparam int SEND_IDLE_PCT [N_PHASES] = '{0, 62, 0, 32};
    localparam int RECV_STALL_PCT [N_PHASES] = '{0, 0, 62, 32};

    // How a transaction's outcome is checked.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_SILENT,
        CHK_FIXED
    } t_row_check;

    typedef struct {
        logic [7:0] value;
        logic       last;
        t_row_check check;
        t_result    want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    u8d_byte_if in_bytes ();
    u8d_cp_if   out_cps ();

    utf8_byte_stream_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bytes),
        .o_out   (out_cps)
    );

    // Shadow decoder state and the code points still awaited from the block.
    t_state    decoder_state;
    t_result   pending_code_points [$];
    t_stim_row directed_rows [$];

    t_row_check cur_check;
    t_result    cur_want;

    int send_idle_pct;
    int recv_stall_pct;
    int bytes_sent;
    int texts_sent;
    int results_seen;
    int mismatches;
    int quiet_cycles;
    int status_count [4];

    t_result predicted;
    t_result received;
    t_result awaited;
    bit      emits;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: stalls at random in proportion to the current phase.
    initial begin
        out_cps.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_cps.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // An error clears the shadow state; it halts unless the text ends here.
    function automatic bit enter_error(input logic [1:0] st, input logic last,
                                       output t_result res);
        decoder_state        = '0;
        decoder_state.halted = !last;
        res.code_point       = '0;
        res.status           = st;
        res.text_done        = last;
        return 1'b1;
    endfunction

    // Advances the shadow decoder by one byte; returns 1 when a result is due.
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output t_result res);
        int         ones;
        int         extra;
        logic [7:0] lead_bits;
        res = '0;
        if (decoder_state.halted) begin
            if (last) decoder_state = '0;
            return 1'b0;
        end
        if (decoder_state.remaining == 0) begin
            // Leading ones of the lead byte, less one, give the continuation count.
            ones = 0;
            while (ones < 8 && b[7-ones]) ones++;
            extra = (ones > 0) ? ones - 1 : 0;
            if (extra > 5) return enter_error(ST_BAD_LEAD, last, res);
            lead_bits = b & (8'hFF >> ((extra == 0) ? 1 : extra + 2));
            decoder_state.acc       = {{(CP_W-BYTE_W){1'b0}}, lead_bits};
            decoder_state.remaining = REM_W'(extra);
        end else begin
            if (b[7:6] != 2'b10) return enter_error(ST_BAD_CONT, last, res);
            decoder_state.acc       = {decoder_state.acc[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
            decoder_state.remaining = decoder_state.remaining - 1'b1;
        end
        if (decoder_state.remaining != 0) begin
            if (last) return enter_error(ST_TRUNCATED, 1'b1, res);
            return 1'b0;
        end
        res.code_point    = decoder_state.acc;
        res.status        = ST_OK;
        res.text_done     = last;
        decoder_state.acc = '0;
        if (last) decoder_state = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input t_result want,
                                   input t_result got);
        if (mismatches < 10) begin
            $display("%0t ns: %s: expected cp=%h st=%0d done=%0d, got cp=%h st=%0d done=%0d",
                     $time, what, want.code_point, want.status, want.text_done,
                     got.code_point, got.status, got.text_done);
        end
        mismatches++;
    endtask

    // Drives one byte after a random gap and holds it until the block takes it.
    task automatic push_byte(input logic [7:0] value, input logic last,
                             input t_row_check check, input t_result want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_bytes.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bytes.valid      <= 1'b1;
        in_bytes.byte_value <= value;
        in_bytes.last_byte  <= last;
        cur_check           <= check;
        cur_want            <= want;
        do @(posedge i_clk); while (!in_bytes.ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic add_row(input logic [7:0] value, input logic last, input t_row_check check,
                           input logic [CP_W-1:0] cp, input logic [1:0] st, input logic done);
        t_stim_row row;
        row.value           = value;
        row.last            = last;
        row.check           = check;
        row.want.code_point = cp;
        row.want.status     = st;
        row.want.text_done  = done;
        directed_rows       = {directed_rows, row};
    endtask

    // Builds one random text of whole code points, sometimes damaged, and sends it.
    task automatic send_text();
        logic [7:0] text_bytes [$];
        logic [7:0] lead;
        int         n_cp;
        int         pick;
        int         extra;
        int         shape;
        n_cp = $urandom_range(1, 6);
        for (int i = 0; i < n_cp; i++) begin
            // Short sequences dominate; five and six byte forms still turn up.
            pick  = $urandom_range(0, 9);
            extra = (pick < 4) ? 0 : (pick < 6) ? 1 : pick - 4;
            if (extra == 0) begin
                lead = ($urandom_range(0, 7) == 0) ? {2'b10, 6'($urandom)}
                                                   : {1'b0, 7'($urandom)};
            end else begin
                lead = (8'hFF << (7 - extra)) | (8'($urandom) & (8'hFF >> (extra + 2)));
            end
            text_bytes = {text_bytes, lead};
            for (int k = 0; k < extra; k++) text_bytes = {text_bytes, {2'b10, 6'($urandom)}};
        end
        // Seven texts in ten are left as built; the rest are damaged in one of four ways.
        shape = $urandom_range(0, 99);
        if (shape >= 93) begin
            foreach (text_bytes[i]) text_bytes[i] = 8'($urandom);
        end else if (shape >= 86) begin
            text_bytes[$urandom_range(0, text_bytes.size() - 1)] =
                ($urandom_range(0, 1) != 0) ? 8'hFE : 8'hFF;
        end else if (shape >= 78) begin
            if (text_bytes.size() > 1) begin
                repeat ($urandom_range(1, text_bytes.size() - 1)) void'(text_bytes.pop_back());
            end
        end else if (shape >= 70) begin
            text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom);
        end
        foreach (text_bytes[i]) begin
            push_byte(text_bytes[i], i == text_bytes.size() - 1, CHK_MODEL, '0);
        end
        texts_sent++;
    endtask

    // Predicts on every accepted byte, checks every accepted result, and
    // watches for a stalled handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bytes.valid && in_bytes.ready) begin
                emits = decode_byte(in_bytes.byte_value, in_bytes.last_byte, predicted);
                if (cur_check == CHK_FIXED) begin
                    pending_code_points = {pending_code_points, cur_want};
                end else if (cur_check == CHK_MODEL && emits) begin
                    pending_code_points = {pending_code_points, predicted};
                end
            end
            if (out_cps.valid && out_cps.ready) begin
                received.code_point = out_cps.code_point;
                received.status     = out_cps.status;
                received.text_done  = out_cps.text_done;
                results_seen++;
                status_count[received.status]++;
                if (pending_code_points.size() == 0) begin
                    report_mismatch("result with none pending", '0, received);
                end else begin
                    awaited = pending_code_points.pop_front();
                    if (received.code_point != awaited.code_point ||
                        received.status != awaited.status ||
                        received.text_done != awaited.text_done) begin
                        report_mismatch("result mismatch", awaited, received);
                    end
                end
            end
            if ((in_bytes.valid && in_bytes.ready) || (out_cps.valid && out_cps.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles.", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        i_rst_n             = 1'b0;
        in_bytes.valid      = 1'b0;
        in_bytes.byte_value = '0;
        in_bytes.last_byte  = 1'b0;
        cur_check           = CHK_MODEL;
        cur_want            = '0;
        decoder_state       = '0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        bytes_sent          = 0;
        texts_sent          = 0;
        results_seen        = 0;
        mismatches          = 0;
        quiet_cycles        = 0;
        foreach (status_count[i]) status_count[i] = 0;

        // The smallest single-byte code point and a lone continuation byte straight after reset.
        add_row(8'h00, 1'b0, CHK_FIXED,  31'h0,        ST_OK,        1'b0);
        add_row(8'hBF, 1'b0, CHK_FIXED,  31'h3F,       ST_OK,        1'b0);
        // Three and four byte code points.
        add_row(8'hE2, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        add_row(8'h82, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        add_row(8'hAC, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        add_row(8'hF0, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        add_row(8'h9F, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        add_row(8'h98, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        add_row(8'h80, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        // Largest six byte code point.
        add_row(8'hFD, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        add_row(8'hBF, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        add_row(8'hBF, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        add_row(8'hBF, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        add_row(8'hBF, 1'b0, CHK_MODEL,  31'h0,        ST_OK,        1'b0);
        add_row(8'hBF, 1'b0, CHK_FIXED,  31'h7FFFFFFF, ST_OK,        1'b0);
        // Bad lead halts; bytes are then ignored until the last one rearms.
        add_row(8'hFE, 1'b0, CHK_FIXED,  31'h0,        ST_BAD_LEAD,  1'b0);
        add_row(8'h41, 1'b0, CHK_SILENT, 31'h0,        ST_OK,        1'b0);
        add_row(8'h7F, 1'b1, CHK_SILENT, 31'h0,        ST_OK,        1'b0);
        // Bad continuation, then rearm.
        add_row(8'hC3, 1'b0, CHK_SILENT, 31'h0,        ST_OK,        1'b0);
        add_row(8'h41, 1'b0, CHK_FIXED,  31'h0,        ST_BAD_CONT,  1'b0);
        add_row(8'h00, 1'b1, CHK_SILENT, 31'h0,        ST_OK,        1'b0);
        // Text cut short in the middle of a sequence.
        add_row(8'hE2, 1'b0, CHK_SILENT, 31'h0,        ST_OK,        1'b0);
        add_row(8'h82, 1'b1, CHK_FIXED,  31'h0,        ST_TRUNCATED, 1'b1);
        // Error on the last byte rearms at once; the next text decodes normally.
        add_row(8'hFF, 1'b1, CHK_FIXED,  31'h0,        ST_BAD_LEAD,  1'b1);
        add_row(8'h7F, 1'b1, CHK_FIXED,  31'h7F,       ST_OK,        1'b1);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            push_byte(directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].check, directed_rows[i].want);
        end

        // Hold the sender back until every awaited result has drained.
        in_bytes.valid <= 1'b0;
        do @(negedge i_clk); while (pending_code_points.size() != 0);

        // Random texts under each handshake pattern.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            int phase_start;
            send_idle_pct  = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            phase_start    = bytes_sent;
            while (bytes_sent - phase_start < BYTES_PER_PHASE) send_text();
        end

        in_bytes.valid <= 1'b0;
        do @(posedge i_clk); while (pending_code_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_code_points.size() != 0) begin
            $display("%0d results never arrived.", pending_code_points.size());
            mismatches += pending_code_points.size();
        end
        $display("Sent %0d bytes (%0d random texts) under four handshake patterns; %0d results.",
                 bytes_sent, texts_sent, results_seen);
        $display("Results by status: ok %0d, bad lead %0d, bad continuation %0d, truncated %0d.",
                 status_count[ST_OK], status_count[ST_BAD_LEAD],
                 status_count[ST_BAD_CONT], status_count[ST_TRUNCATED]);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches in total.", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
